// ----- rtl/core/mse_pkg.sv -----
// mse_pkg: shared types and constants of the MIPS subset execute core.
// No dependencies; used by mse_regfile, mse_execute and mips_subset_execute_core.
package mse_pkg;

   localparam int WORD_W              = 32;
   localparam int REG_ADDR_W          = 5;
   localparam int REGISTER_COUNT      = 32;
   localparam int INDEX_W             = 13;
   localparam int REQ_TDATA_W         = 144;
   localparam int RSP_TDATA_W         = 128;

   localparam logic [INDEX_W-1:0]    PROGRAM_DEPTH       = 13'd4096;
   localparam logic [INDEX_W-1:0]    PROGRAM_LENGTH_RST  = 13'd1;
   localparam logic [WORD_W-1:0]     STACK_TOP           = 32'd1048576;
   localparam logic [REG_ADDR_W-1:0] STACK_POINTER_INDEX = 5'd29;
   localparam logic [WORD_W-1:0]     KERNEL_REG_A        = 32'd26;
   localparam logic [WORD_W-1:0]     KERNEL_REG_B        = 32'd27;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_ADDI = 4'd1,
      OP_SUB  = 4'd2,
      OP_MUL  = 4'd3,
      OP_BEQ  = 4'd4,
      OP_BNE  = 4'd5,
      OP_SLT  = 4'd6,
      OP_J    = 4'd7,
      OP_SW   = 4'd8,
      OP_LW   = 4'd9
   } op_type;

   typedef enum logic [2:0] {
      ERR_NONE           = 3'd0,
      ERR_BAD_REG        = 3'd1,
      ERR_OVERFLOW       = 3'd2,
      ERR_MISALIGNED     = 3'd3,
      ERR_OUT_OF_PROGRAM = 3'd4,
      ERR_KERNEL_REG     = 3'd5
   } err_type;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_READ  = 2'd1,
      MEM_WRITE = 2'd2
   } mem_req_type;

   typedef enum logic {
      CMD_EXECUTE     = 1'b0,
      CMD_LOAD_RETURN = 1'b1
   } cmd_type;

   // packed from the top bit down; the fields after command match req_tdata
   typedef struct packed {
      cmd_type                command;
      logic [WORD_W-1:0]      return_value;
      logic [REG_ADDR_W-1:0]  return_register;
      logic [WORD_W-1:0]      arg_third;
      logic [WORD_W-1:0]      arg_second;
      logic [WORD_W-1:0]      arg_first;
      logic [3:0]             opcode;
   } req_item_type;

   localparam int REQ_FIELDS_W = $bits(req_item_type) - 1;

   // packed from the top bit down; matches rsp_tdata below the padding
   typedef struct packed {
      logic [WORD_W-1:0]      wb_value;
      logic [REG_ADDR_W-1:0]  wb_register;
      logic                   wb_valid;
      logic [REG_ADDR_W-1:0]  mem_dest_register;
      logic [WORD_W-1:0]      mem_write_data;
      logic [WORD_W-1:0]      mem_address;
      mem_req_type            mem_request;
      err_type                error_code;
      logic                   halted;
      logic [INDEX_W-1:0]     next_index;
   } exec_result_type;

   localparam int RSP_PAD_W = RSP_TDATA_W - $bits(exec_result_type);

endpackage

// ----- rtl/core/mips_subset_execute_core.sv -----
// mips_subset_execute_core: an accepted word is held in the input register, executed by
// the single execute stage and captured in the result register; one word per cycle
// sustained while the result side does not stall. Register file reads are registered
// at accept and bypassed from the write of the preceding word.
// Reset: program index 0, halt clear, program length 1, all registers read zero
// except the stack pointer, which reads the stack top, until written.
module mips_subset_execute_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // opcode, arg_first, arg_second, arg_third, return_register, return_value, zero pad
   input  logic [mse_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // command
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // next_index, halted, error_code, mem_request, mem_address, mem_write_data,
   // mem_dest_register, wb_valid, wb_register, wb_value, zero pad
   output logic [mse_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_we,
   input  logic [mse_pkg::INDEX_W-1:0]          csr_wdata
);

   logic                                     a_valid_ff;
   mse_pkg::req_item_type                    a_item_ff;
   logic                                     rsp_valid_ff;
   mse_pkg::exec_result_type                 rsp_res_ff;
   logic [mse_pkg::INDEX_W-1:0]              pc_ff;
   logic                                     halt_ff;
   logic [mse_pkg::INDEX_W-1:0]              len_ff;

   logic                                     a_adv;
   logic                                     req_acc;
   logic [mse_pkg::INDEX_W-1:0]              active_len;
   mse_pkg::op_type                          req_op;
   logic [1:0][mse_pkg::REG_ADDR_W-1:0]      rd_addr;
   logic [1:0][mse_pkg::WORD_W-1:0]          rd_data;
   mse_pkg::exec_result_type                 exe_res;
   logic                                     rf_we;

   assign a_adv      = a_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || a_adv;
   assign req_acc    = req_tvalid && req_tready;
   assign active_len = (len_ff > mse_pkg::PROGRAM_DEPTH) ? mse_pkg::PROGRAM_DEPTH : len_ff;

   // port 0: rs / branch first / store data; port 1: rt / branch second / base
   assign req_op = mse_pkg::op_type'(req_tdata[3:0]);
   always_comb begin
      rd_addr[0] = req_tdata[40:36];
      rd_addr[1] = req_tdata[72:68];
      if (req_op inside {mse_pkg::OP_BEQ, mse_pkg::OP_BNE, mse_pkg::OP_SW}) begin
         rd_addr[0] = req_tdata[8:4];
      end
      if (req_op inside {mse_pkg::OP_BEQ, mse_pkg::OP_BNE}) begin
         rd_addr[1] = req_tdata[40:36];
      end
   end

   assign rf_we = a_adv && exe_res.wb_valid;

   mse_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_acc),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (rf_we),
      .wr_addr (exe_res.wb_register),
      .wr_data (exe_res.wb_value)
   );

   mse_execute u_execute (
      .item       (a_item_ff),
      .rs_value   (rd_data[0]),
      .rt_value   (rd_data[1]),
      .pc         (pc_ff),
      .halt       (halt_ff),
      .active_len (active_len),
      .res        (exe_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         len_ff       <= mse_pkg::PROGRAM_LENGTH_RST;
      end else begin
         if (req_acc) begin
            a_valid_ff <= 1'b1;
         end else if (a_adv) begin
            a_valid_ff <= 1'b0;
         end
         if (a_adv) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= exe_res.next_index;
            halt_ff      <= halt_ff || (exe_res.error_code != mse_pkg::ERR_NONE);
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_item_ff <= {mse_pkg::cmd_type'(req_tuser), req_tdata[mse_pkg::REQ_FIELDS_W-1:0]};
      end
      if (a_adv) begin
         rsp_res_ff <= exe_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{mse_pkg::RSP_PAD_W{1'b0}}, rsp_res_ff};

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared");

   a_error_holds_pc: assert property (@(posedge clock) disable iff (reset)
      a_adv && (exe_res.error_code != mse_pkg::ERR_NONE) |=> halt_ff && $stable(pc_ff))
      else $error("failing word changed program index or left halt clear");

   a_error_no_side_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_res_ff.error_code != mse_pkg::ERR_NONE) |->
         !rsp_res_ff.wb_valid && (rsp_res_ff.mem_request == mse_pkg::MEM_NONE) &&
         rsp_res_ff.halted)
      else $error("failing word produced write-back or memory request");

   a_no_zero_writeback: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> (exe_res.wb_register != '0))
      else $error("write-back to register zero");

endmodule

// ----- rtl/core/mse_regfile.sv -----
// mse_regfile: 32-entry register file, two registered read ports, one write port.
// Entries not yet written read as their reset value; same-edge writes are bypassed.
// Depends on mse_pkg.
module mse_regfile (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      rd_en,
   input  logic [1:0][mse_pkg::REG_ADDR_W-1:0]       rd_addr,
   output logic [1:0][mse_pkg::WORD_W-1:0]           rd_data,
   input  logic                                      wr_en,
   input  logic [mse_pkg::REG_ADDR_W-1:0]            wr_addr,
   input  logic [mse_pkg::WORD_W-1:0]                wr_data
);

   logic [mse_pkg::WORD_W-1:0]         rf_ff [mse_pkg::REGISTER_COUNT];
   logic [mse_pkg::REGISTER_COUNT-1:0] valid_ff;
   logic [1:0][mse_pkg::WORD_W-1:0]    q_ff;
   logic [1:0]                         q_valid_ff;
   logic [1:0]                         q_sp_ff;
   logic [1:0]                         byp_ff;
   logic [mse_pkg::WORD_W-1:0]         byp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         for (int p = 0; p < 2; p++) begin
            q_ff[p]       <= rf_ff[rd_addr[p]];
            q_valid_ff[p] <= valid_ff[rd_addr[p]];
            q_sp_ff[p]    <= (rd_addr[p] == mse_pkg::STACK_POINTER_INDEX);
            byp_ff[p]     <= wr_en && (wr_addr == rd_addr[p]);
         end
         byp_data_ff <= wr_data;
      end
   end

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         if (byp_ff[p]) begin
            rd_data[p] = byp_data_ff;
         end else if (q_valid_ff[p]) begin
            rd_data[p] = q_ff[p];
         end else if (q_sp_ff[p]) begin
            rd_data[p] = mse_pkg::STACK_TOP;
         end else begin
            rd_data[p] = '0;
         end
      end
   end

endmodule

// ----- rtl/core/mse_execute.sv -----
// mse_execute: combinational execute step for one word (decode, ALU, branch, memory).
// Depends on mse_pkg; operands come from mse_regfile read ports.
module mse_execute (
   input  mse_pkg::req_item_type               item,
   input  logic [mse_pkg::WORD_W-1:0]          rs_value,
   input  logic [mse_pkg::WORD_W-1:0]          rt_value,
   input  logic [mse_pkg::INDEX_W-1:0]         pc,
   input  logic                                halt,
   input  logic [mse_pkg::INDEX_W-1:0]         active_len,
   output mse_pkg::exec_result_type            res
);

   localparam int ADDR_EXT_W = mse_pkg::WORD_W + 2;

   function automatic logic reg_ok(input logic [mse_pkg::WORD_W-1:0] r);
      return r[mse_pkg::WORD_W-1:mse_pkg::REG_ADDR_W] == '0;
   endfunction

   function automatic mse_pkg::err_type jump_err(input logic [ADDR_EXT_W-1:0] byte_addr,
                                                 input logic [mse_pkg::INDEX_W-1:0] limit);
      if (byte_addr[1:0] != 2'b00) begin
         return mse_pkg::ERR_MISALIGNED;
      end
      if (byte_addr[ADDR_EXT_W-1] ||
          (byte_addr[ADDR_EXT_W-1:2] >=
           {{(mse_pkg::WORD_W-mse_pkg::INDEX_W){1'b0}}, limit})) begin
         return mse_pkg::ERR_OUT_OF_PROGRAM;
      end
      return mse_pkg::ERR_NONE;
   endfunction

   mse_pkg::op_type               op;
   mse_pkg::err_type              err;
   logic                          is_alu;
   logic                          add_op;
   logic [mse_pkg::WORD_W:0]      alu_q;
   logic [ADDR_EXT_W-1:0]         br_addr;
   logic [ADDR_EXT_W-1:0]         j_addr;
   logic                          taken;

   assign op      = mse_pkg::op_type'(item.opcode);
   assign br_addr = {{(ADDR_EXT_W-mse_pkg::INDEX_W-2){1'b0}}, pc, 2'b00}
                    + {{2{item.arg_third[mse_pkg::WORD_W-1]}}, item.arg_third};
   assign j_addr  = {{2{item.arg_first[mse_pkg::WORD_W-1]}}, item.arg_first};
   assign taken   = (rs_value == rt_value) == (op == mse_pkg::OP_BEQ);

   always_comb begin
      res            = '0;
      res.next_index = pc;
      err            = mse_pkg::ERR_NONE;
      is_alu         = 1'b0;
      add_op         = 1'b0;
      alu_q          = '0;
      if (item.command == mse_pkg::CMD_LOAD_RETURN) begin
         if (item.return_register != '0) begin
            res.wb_valid    = 1'b1;
            res.wb_register = item.return_register;
            res.wb_value    = item.return_value;
         end
      end else if (!halt && (pc < active_len)) begin
         case (op)
            mse_pkg::OP_ADD, mse_pkg::OP_ADDI, mse_pkg::OP_SUB,
            mse_pkg::OP_MUL, mse_pkg::OP_SLT: begin
               res.next_index = pc + 1'b1;
               if (!reg_ok(item.arg_first) || !reg_ok(item.arg_second) ||
                   ((op != mse_pkg::OP_ADDI) && !reg_ok(item.arg_third))) begin
                  err = mse_pkg::ERR_BAD_REG;
               end else begin
                  is_alu = 1'b1;
                  add_op = op inside {mse_pkg::OP_ADD, mse_pkg::OP_ADDI, mse_pkg::OP_SUB};
                  case (op)
                     mse_pkg::OP_ADD:  alu_q = {rs_value[mse_pkg::WORD_W-1], rs_value}
                                             + {rt_value[mse_pkg::WORD_W-1], rt_value};
                     mse_pkg::OP_ADDI: alu_q = {rs_value[mse_pkg::WORD_W-1], rs_value}
                                             + {item.arg_third[mse_pkg::WORD_W-1],
                                                item.arg_third};
                     mse_pkg::OP_SUB:  alu_q = {rs_value[mse_pkg::WORD_W-1], rs_value}
                                             - {rt_value[mse_pkg::WORD_W-1], rt_value};
                     mse_pkg::OP_MUL:  alu_q = {1'b0, rs_value * rt_value};
                     mse_pkg::OP_SLT:  alu_q = {{mse_pkg::WORD_W{1'b0}},
                                                ($signed(rs_value) < $signed(rt_value))};
                     default:          alu_q = '0;
                  endcase
               end
            end
            mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
               res.next_index = pc + 1'b1;
               if (!reg_ok(item.arg_first) || !reg_ok(item.arg_second)) begin
                  err = mse_pkg::ERR_BAD_REG;
               end else if (taken) begin
                  err            = jump_err(br_addr, active_len);
                  res.next_index = br_addr[mse_pkg::INDEX_W+1:2] + 1'b1;
               end
            end
            mse_pkg::OP_J: begin
               err            = jump_err(j_addr, active_len);
               res.next_index = item.arg_first[mse_pkg::INDEX_W+1:2];
            end
            mse_pkg::OP_SW: begin
               res.next_index = pc + 1'b1;
               if (!reg_ok(item.arg_third) || !reg_ok(item.arg_first)) begin
                  err = mse_pkg::ERR_BAD_REG;
               end else begin
                  res.mem_request    = mse_pkg::MEM_WRITE;
                  res.mem_address    = rt_value + item.arg_second;
                  res.mem_write_data = rs_value;
               end
            end
            mse_pkg::OP_LW: begin
               res.next_index = pc + 1'b1;
               if (!reg_ok(item.arg_first) || !reg_ok(item.arg_third)) begin
                  err = mse_pkg::ERR_BAD_REG;
               end else begin
                  res.mem_request       = mse_pkg::MEM_READ;
                  res.mem_address       = rt_value + item.arg_second;
                  res.mem_dest_register = item.arg_first[mse_pkg::REG_ADDR_W-1:0];
               end
            end
            default: begin
               res.next_index = pc;
            end
         endcase

         if ((err == mse_pkg::ERR_NONE) && is_alu) begin
            if (add_op && (alu_q[mse_pkg::WORD_W] != alu_q[mse_pkg::WORD_W-1])) begin
               err = mse_pkg::ERR_OVERFLOW;
            end else if (item.arg_first inside {mse_pkg::KERNEL_REG_A,
                                                mse_pkg::KERNEL_REG_B}) begin
               err = mse_pkg::ERR_KERNEL_REG;
            end else if (item.arg_first != '0) begin
               res.wb_valid    = 1'b1;
               res.wb_register = item.arg_first[mse_pkg::REG_ADDR_W-1:0];
               res.wb_value    = alu_q[mse_pkg::WORD_W-1:0];
            end
         end

         if (err != mse_pkg::ERR_NONE) begin
            res.next_index        = pc;
            res.mem_request       = mse_pkg::MEM_NONE;
            res.mem_address       = '0;
            res.mem_write_data    = '0;
            res.mem_dest_register = '0;
            res.wb_valid          = 1'b0;
            res.wb_register       = '0;
            res.wb_value          = '0;
         end
      end
      res.error_code = err;
      res.halted     = halt || (err != mse_pkg::ERR_NONE) || (res.next_index >= active_len);
   end

endmodule

// ----- tb/tb_mips_subset_execute_core.sv -----
// tb_mips_subset_execute_core: self-checking bench for the MIPS subset execute core.
// Drives instruction and load-return words, predicts every result word in a scoreboard
// class and compares field by field. Depends on mse_pkg and mips_subset_execute_core.
module tb_mips_subset_execute_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES = 3000;
   localparam int HOLD_CYCLES     = 200;
   localparam int RANDOM_WORDS    = 1250;

   class core_scoreboard;
      logic [mse_pkg::WORD_W-1:0]   regs [mse_pkg::REGISTER_COUNT];
      logic [mse_pkg::INDEX_W-1:0]  pc;
      logic [mse_pkg::INDEX_W-1:0]  prog_len;
      bit                           halt;
      mse_pkg::exec_result_type     pending_results [$];
      int                           mismatches;

      function new();
         foreach (regs[i]) regs[i] = '0;
         regs[mse_pkg::STACK_POINTER_INDEX] = mse_pkg::STACK_TOP;
         pc         = '0;
         prog_len   = mse_pkg::PROGRAM_LENGTH_RST;
         halt       = 1'b0;
         mismatches = 0;
      endfunction

      function logic [mse_pkg::INDEX_W-1:0] eff_len();
         return (prog_len > mse_pkg::PROGRAM_DEPTH) ? mse_pkg::PROGRAM_DEPTH : prog_len;
      endfunction

      function bit at_end();
         return halt || pc >= eff_len();
      endfunction

      function bit bad_reg(longint r);
         return r < 0 || r >= mse_pkg::REGISTER_COUNT;
      endfunction

      function longint reg_signed(longint r);
         return longint'(signed'(regs[r[4:0]]));
      endfunction

      function mse_pkg::err_type check_target(longint byte_addr,
                                              output logic [mse_pkg::INDEX_W-1:0] idx);
         idx = '0;
         if (byte_addr[1:0] != 2'b00) return mse_pkg::ERR_MISALIGNED;
         if (byte_addr < 0 || byte_addr / 4 >= longint'(eff_len()))
            return mse_pkg::ERR_OUT_OF_PROGRAM;
         idx = mse_pkg::INDEX_W'(byte_addr / 4);
         return mse_pkg::ERR_NONE;
      endfunction

      // result of one word; state is updated only when commit is set
      function mse_pkg::exec_result_type execute_word(mse_pkg::req_item_type w, bit commit);
         mse_pkg::exec_result_type     r;
         longint                       a1, a2, a3, res;
         logic [mse_pkg::INDEX_W-1:0]  nxt, tgt, new_pc;
         logic [mse_pkg::WORD_W-1:0]   prod;
         mse_pkg::err_type             e;
         bit                           alu, new_halt;
         r        = '0;
         e        = mse_pkg::ERR_NONE;
         alu      = 1'b0;
         res      = 0;
         tgt      = '0;
         nxt      = '0;
         new_pc   = pc;
         new_halt = halt;
         a1       = longint'(signed'(w.arg_first));
         a2       = longint'(signed'(w.arg_second));
         a3       = longint'(signed'(w.arg_third));
         if (w.command == mse_pkg::CMD_LOAD_RETURN) begin
            if (w.return_register != '0) begin
               r.wb_valid    = 1'b1;
               r.wb_register = w.return_register;
               r.wb_value    = w.return_value;
               if (commit) regs[w.return_register] = w.return_value;
            end
         end else if (!halt && pc < eff_len() && w.opcode <= mse_pkg::OP_LW) begin
            nxt = pc + 1'b1;
            case (w.opcode)
               mse_pkg::OP_ADD, mse_pkg::OP_SUB, mse_pkg::OP_MUL, mse_pkg::OP_SLT: begin
                  if (bad_reg(a1) || bad_reg(a2) || bad_reg(a3)) begin
                     e = mse_pkg::ERR_BAD_REG;
                  end else begin
                     alu = 1'b1;
                     case (w.opcode)
                        mse_pkg::OP_ADD: res = reg_signed(a2) + reg_signed(a3);
                        mse_pkg::OP_SUB: res = reg_signed(a2) - reg_signed(a3);
                        mse_pkg::OP_SLT: res = (reg_signed(a2) < reg_signed(a3)) ? 1 : 0;
                        default: begin
                           prod = regs[a2[4:0]] * regs[a3[4:0]];
                           res  = longint'(signed'(prod));
                        end
                     endcase
                  end
               end
               mse_pkg::OP_ADDI: begin
                  if (bad_reg(a1) || bad_reg(a2)) begin
                     e = mse_pkg::ERR_BAD_REG;
                  end else begin
                     alu = 1'b1;
                     res = reg_signed(a2) + a3;
                  end
               end
               mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
                  if (bad_reg(a1) || bad_reg(a2)) begin
                     e = mse_pkg::ERR_BAD_REG;
                  end else if ((reg_signed(a1) == reg_signed(a2)) ==
                               (w.opcode == mse_pkg::OP_BEQ)) begin
                     e   = check_target(longint'(pc) * 4 + a3, tgt);
                     nxt = tgt + 1'b1;
                  end
               end
               mse_pkg::OP_J: begin
                  e   = check_target(a1, tgt);
                  nxt = tgt;
               end
               mse_pkg::OP_SW: begin
                  if (bad_reg(a3) || bad_reg(a1)) begin
                     e = mse_pkg::ERR_BAD_REG;
                  end else begin
                     r.mem_request    = mse_pkg::MEM_WRITE;
                     r.mem_address    = regs[a3[4:0]] + w.arg_second;
                     r.mem_write_data = regs[a1[4:0]];
                  end
               end
               mse_pkg::OP_LW: begin
                  if (bad_reg(a1) || bad_reg(a3)) begin
                     e = mse_pkg::ERR_BAD_REG;
                  end else begin
                     r.mem_request       = mse_pkg::MEM_READ;
                     r.mem_address       = regs[a3[4:0]] + w.arg_second;
                     r.mem_dest_register = a1[4:0];
                  end
               end
               default: ;
            endcase
            if (e == mse_pkg::ERR_NONE && alu) begin
               if (w.opcode inside {mse_pkg::OP_ADD, mse_pkg::OP_ADDI, mse_pkg::OP_SUB} &&
                   res != longint'(signed'(res[31:0]))) begin
                  e = mse_pkg::ERR_OVERFLOW;
               end else if (a1 == longint'(mse_pkg::KERNEL_REG_A) ||
                            a1 == longint'(mse_pkg::KERNEL_REG_B)) begin
                  e = mse_pkg::ERR_KERNEL_REG;
               end else if (a1 != 0) begin
                  r.wb_valid    = 1'b1;
                  r.wb_register = a1[4:0];
                  r.wb_value    = res[31:0];
                  if (commit) regs[a1[4:0]] = res[31:0];
               end
            end
            if (e != mse_pkg::ERR_NONE) new_halt = 1'b1;
            else new_pc = nxt;
         end
         r.error_code = e;
         r.next_index = new_pc;
         r.halted     = new_halt || new_pc >= eff_len();
         if (commit) begin
            pc   = new_pc;
            halt = new_halt;
         end
         return r;
      endfunction

      function void note_word(mse_pkg::req_item_type w);
         pending_results.insert(pending_results.size(), execute_word(w, 1'b1));
      endfunction

      function void flag(string field, logic [mse_pkg::WORD_W-1:0] want,
                         logic [mse_pkg::WORD_W-1:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
      endfunction

      function void check_word(mse_pkg::exec_result_type got);
         mse_pkg::exec_result_type want;
         if (pending_results.size() == 0) begin
            flag("word with nothing pending, next_index", '0, got.next_index);
            return;
         end
         want = pending_results.pop_front();
         if (got.next_index !== want.next_index) flag("next_index", want.next_index, got.next_index);
         if (got.halted !== want.halted) flag("halted", want.halted, got.halted);
         if (got.error_code !== want.error_code) flag("error_code", want.error_code, got.error_code);
         if (got.mem_request !== want.mem_request)
            flag("mem_request", want.mem_request, got.mem_request);
         if (got.mem_address !== want.mem_address)
            flag("mem_address", want.mem_address, got.mem_address);
         if (got.mem_write_data !== want.mem_write_data)
            flag("mem_write_data", want.mem_write_data, got.mem_write_data);
         if (got.mem_dest_register !== want.mem_dest_register)
            flag("mem_dest_register", want.mem_dest_register, got.mem_dest_register);
         if (got.wb_valid !== want.wb_valid) flag("wb_valid", want.wb_valid, got.wb_valid);
         if (got.wb_register !== want.wb_register)
            flag("wb_register", want.wb_register, got.wb_register);
         if (got.wb_value !== want.wb_value) flag("wb_value", want.wb_value, got.wb_value);
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [mse_pkg::REQ_TDATA_W-1:0]   req_tdata = '0;
   logic                              req_tuser = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [mse_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic                              csr_we = 1'b0;
   logic [mse_pkg::INDEX_W-1:0]       csr_wdata = '0;

   core_scoreboard                    core_sb = new();
   int                                send_idle_pct = 0;
   int                                recv_stall_pct = 0;
   int                                hold_asked = 0;
   int                                hold_seen = 0;
   int                                hold_left = 0;
   int                                quiet = 0;
   int                                random_sent = 0;
   bit                                held_once = 1'b0;
   logic [mse_pkg::REG_ADDR_W-1:0]    last_load_dst = '0;

   mips_subset_execute_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // result side: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         hold_seen  <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         core_sb.check_word(rsp_tdata[$bits(mse_pkg::exec_result_type)-1:0]);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic logic [mse_pkg::WORD_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'hffffffff;
         3: return 32'($urandom_range(0, 64) - 32);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [mse_pkg::WORD_W-1:0] pick_dest();
      logic [mse_pkg::WORD_W-1:0] d;
      do d = 32'($urandom_range(0, mse_pkg::REGISTER_COUNT - 1));
      while (d == mse_pkg::KERNEL_REG_A || d == mse_pkg::KERNEL_REG_B);
      return d;
   endfunction

   function automatic logic [mse_pkg::WORD_W-1:0] pick_target_addr();
      return 32'($urandom_range(0, int'(core_sb.eff_len()) - 1)) << 2;
   endfunction

   // well-formed instruction or load-return word for the current index; random fields where unused
   function automatic mse_pkg::req_item_type random_word();
      mse_pkg::req_item_type w;
      w.command         = mse_pkg::CMD_EXECUTE;
      w.opcode          = 4'($urandom_range(0, 9));
      w.arg_first       = $urandom();
      w.arg_second      = $urandom();
      w.arg_third       = $urandom();
      w.return_register = 5'($urandom());
      w.return_value    = pick_value();
      if ($urandom_range(0, 99) < 20) begin
         w.command = mse_pkg::CMD_LOAD_RETURN;
         if ($urandom_range(0, 1) == 1) w.return_register = last_load_dst;
         return w;
      end
      if (int'(core_sb.pc) + 1 >= int'(core_sb.eff_len()) &&
          (core_sb.eff_len() == mse_pkg::PROGRAM_DEPTH || $urandom_range(0, 9) != 0))
         w.opcode = mse_pkg::OP_J;
      case (w.opcode)
         mse_pkg::OP_ADD, mse_pkg::OP_SUB, mse_pkg::OP_MUL, mse_pkg::OP_SLT: begin
            w.arg_first  = pick_dest();
            w.arg_second = 32'($urandom_range(0, mse_pkg::REGISTER_COUNT - 1));
            w.arg_third  = 32'($urandom_range(0, mse_pkg::REGISTER_COUNT - 1));
         end
         mse_pkg::OP_ADDI: begin
            w.arg_first  = pick_dest();
            w.arg_second = 32'($urandom_range(0, mse_pkg::REGISTER_COUNT - 1));
            w.arg_third  = pick_value();
         end
         mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
            w.arg_first  = 32'($urandom_range(0, mse_pkg::REGISTER_COUNT - 1));
            w.arg_second = ($urandom_range(0, 2) == 0)
                           ? w.arg_first
                           : 32'($urandom_range(0, mse_pkg::REGISTER_COUNT - 1));
            w.arg_third  = pick_target_addr() - {17'b0, core_sb.pc, 2'b00};
         end
         mse_pkg::OP_J: w.arg_first = pick_target_addr();
         default: begin
            w.arg_first  = 32'($urandom_range(0, mse_pkg::REGISTER_COUNT - 1));
            w.arg_second = pick_value();
            w.arg_third  = 32'($urandom_range(0, mse_pkg::REGISTER_COUNT - 1));
         end
      endcase
      return w;
   endfunction

   // entered and left at a falling edge
   task automatic send_word(input mse_pkg::req_item_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w[mse_pkg::REQ_FIELDS_W-1:0];
      req_tuser  <= w.command;
      do @(posedge clock); while (!req_tready);
      core_sb.note_word(w);
      if (w.command == mse_pkg::CMD_EXECUTE && w.opcode == mse_pkg::OP_LW)
         last_load_dst = w.arg_first[4:0];
      @(negedge clock);
   endtask

   task automatic send_exec(input mse_pkg::op_type op,
                            input logic [mse_pkg::WORD_W-1:0] a1, a2, a3);
      mse_pkg::req_item_type w;
      w.command         = mse_pkg::CMD_EXECUTE;
      w.opcode          = op;
      w.arg_first       = a1;
      w.arg_second      = a2;
      w.arg_third       = a3;
      w.return_register = 5'($urandom());
      w.return_value    = $urandom();
      send_word(w);
   endtask

   task automatic send_load(input logic [mse_pkg::REG_ADDR_W-1:0] rr,
                            input logic [mse_pkg::WORD_W-1:0] rv);
      mse_pkg::req_item_type w;
      w.command         = mse_pkg::CMD_LOAD_RETURN;
      w.opcode          = 4'($urandom());
      w.arg_first       = $urandom();
      w.arg_second      = $urandom();
      w.arg_third       = $urandom();
      w.return_register = rr;
      w.return_value    = rv;
      send_word(w);
   endtask

   task automatic write_length(input logic [mse_pkg::INDEX_W-1:0] len);
      req_tvalid <= 1'b0;
      while (core_sb.pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(negedge clock);
      csr_we           <= 1'b0;
      core_sb.prog_len  = len;
   endtask

   task automatic run_phase(input int mode, input int count);
      mse_pkg::req_item_type    w;
      mse_pkg::exec_result_type probe;
      case (mode)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 56;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 56;
            if (!held_once) begin
               held_once  = 1'b1;
               hold_asked = hold_asked + 1;
            end
         end
         default: begin
            send_idle_pct  = 38;
            recv_stall_pct = 38;
         end
      endcase
      for (int i = 0; i < count && !core_sb.at_end(); i++) begin
         do begin
            w     = random_word();
            probe = core_sb.execute_word(w, 1'b0);
         end while (probe.error_code != mse_pkg::ERR_NONE ||
                    probe.next_index >= mse_pkg::PROGRAM_DEPTH);
         send_word(w);
         random_sent++;
      end
   endtask

   initial begin
      logic [mse_pkg::INDEX_W-1:0] len;
      int                          p;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one-word program: runs off the end, then ignores execution
      write_length(13'd1);
      send_exec(mse_pkg::OP_ADDI, 1, 0, 32'h7fffffff);
      send_exec(mse_pkg::OP_ADD, 3, 1, 1);
      send_load(0, 32'hffffffff);
      write_length(13'd0);
      send_exec(mse_pkg::OP_J, 0, 0, 0);
      // above the program depth, acts as full depth
      write_length(13'h1fff);
      send_load(mse_pkg::KERNEL_REG_A[4:0], 32'h7fffffff);
      send_load(mse_pkg::KERNEL_REG_B[4:0], 32'h00000005);
      send_exec(mse_pkg::OP_ADDI, 2, 0, 32'h80000000);
      send_exec(mse_pkg::OP_ADD, 4, 1, 2);
      send_exec(mse_pkg::OP_SUB, 5, 1, mse_pkg::KERNEL_REG_A);
      send_exec(mse_pkg::OP_MUL, 6, 1, 1);
      send_exec(mse_pkg::OP_SLT, 7, 2, 1);
      send_exec(mse_pkg::OP_SLT, 8, 1, 2);
      send_exec(mse_pkg::OP_ADD, 0, 4, 4);
      send_exec(mse_pkg::OP_SW, 1, 32'hfffffffc, mse_pkg::STACK_POINTER_INDEX);
      send_exec(mse_pkg::OP_LW, 9, 32'h7fffffff, 2);
      send_load(9, 32'hdeadbeef);
      send_exec(mse_pkg::OP_BEQ, 1, 2, 32'h40);
      send_exec(mse_pkg::OP_J, 32'd16380, 0, 0);
      send_exec(mse_pkg::OP_BNE, 1, 2, 32'(-16380));
      send_exec(mse_pkg::OP_BEQ, 3, 3, 32'd8);

      p = 0;
      while (random_sent < RANDOM_WORDS) begin
         case (p % 3)
            0: len = mse_pkg::PROGRAM_DEPTH;
            1: len = (int'(core_sb.pc) + 40 > int'(mse_pkg::PROGRAM_DEPTH))
                     ? mse_pkg::PROGRAM_DEPTH
                     : mse_pkg::INDEX_W'(int'(core_sb.pc) + $urandom_range(4, 40));
            default: len = mse_pkg::INDEX_W'($urandom_range(int'(core_sb.pc) + 1,
                                                            mse_pkg::PROGRAM_DEPTH));
         endcase
         write_length(len);
         run_phase(p % 4, 160);
         p++;
      end

      // the error halt is sticky, so exactly one fault closes the run
      write_length(mse_pkg::PROGRAM_DEPTH);
      send_idle_pct  = 38;
      recv_stall_pct = 38;
      send_load(10, 32'h7fffffff);
      send_load(11, 32'h00000001);
      case ($urandom_range(0, 5))
         0: send_exec(mse_pkg::OP_ADD, 12, 10, 11);
         1: send_exec(mse_pkg::OP_ADDI, 12, 10, 32'h7fffffff);
         2: send_exec(mse_pkg::OP_SLT,
                      ($urandom_range(0, 1) == 1) ? mse_pkg::KERNEL_REG_A
                                                  : mse_pkg::KERNEL_REG_B, 10, 11);
         3: send_exec(mse_pkg::OP_LW, 2, 0, $urandom() | 32'h20);
         4: send_exec(mse_pkg::OP_J,
                      32'(($urandom_range(0, 4095) << 2) | $urandom_range(1, 3)), 0, 0);
         default: send_exec(mse_pkg::OP_J,
                            ($urandom_range(0, 1) == 1) ? 32'h4000 : 32'hfffffffc, 0, 0);
      endcase
      repeat (3) send_exec(mse_pkg::OP_ADDI, 3, 0, 1);
      send_load(mse_pkg::KERNEL_REG_A[4:0], $urandom());

      req_tvalid <= 1'b0;
      while (core_sb.pending_results.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
      if (core_sb.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
